>>> sv/lbsb_pkg.sv
// Shared types and constants for the logarithmic band spectrum bar generator.
// Used by every module of the block; depends on nothing.
package lbsb_pkg;

   localparam int BAND_W      = 7;
   localparam int BAND_NUM_W  = 6;
   localparam int BAR_W       = 11;
   localparam int CSR_W       = 10;
   localparam int CSR_IDX_W   = 2;
   localparam int MULT_W      = 4;
   localparam int HEIGHT_W    = 10;
   localparam int QUEUE_DEPTH = 4;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTIPLIER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAR_HEIGHT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STOPPED_MODE = 2'd3;

   localparam logic [BAND_W-1:0]   BAND_COUNT_RST = 7'd28;
   localparam logic [MULT_W-1:0]   MULTIPLIER_RST = 4'd3;
   localparam logic [HEIGHT_W-1:0] BAR_HEIGHT_RST = 10'd0;
   localparam logic                STOPPED_RST    = 1'b1;

   localparam int FIRST_BAND_END = 2;
   localparam int DIV_W          = 11;  // width of 10 * band index
   localparam int EXP_FRAC       = 40;  // fraction bits of the 2^t evaluation
   localparam int STEP_W         = 6;   // counts the EXP_FRAC steps
   localparam int FLOOR_W        = 14;  // band ends below 2^14
   localparam int BIG_QUOT       = 13;  // exponent of 14 or more saturates

   // floor(h/3) as (h * 683) >> 11, exact for every 10-bit h.
   localparam int DIV3_RECIP = 683;
   localparam int DIV3_SHIFT = 11;

   localparam int K_W       = 13;  // multiplier * floor(h/3) <= 5115
   localparam int K2_W      = 26;
   localparam int ROOT_W    = 13;
   localparam int ROOT_IN_W = 26;
   localparam int Y_W       = 15;
   localparam int BAR_STOPPED = -2;
   localparam int BAR_OFFSET  = 4;

   localparam real LOG2_E = 1.0 / $ln(2.0);

   typedef logic [EXP_FRAC:0] exp_const_type;
   typedef exp_const_type exp_tab_type [EXP_FRAC];

   // log2(1 + 2^-(k+1)) scaled by 2^EXP_FRAC, evaluated at elaboration.
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      real v;
      for (int k = 0; k < EXP_FRAC; k++) begin
         v = $ln(1.0 + 2.0 ** (-(k + 1))) * LOG2_E * (2.0 ** EXP_FRAC);
         tab[k] = (EXP_FRAC + 1)'(longint'(v));
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

   typedef struct packed {
      logic [BAND_NUM_W-1:0] band;
      logic                  last;
      logic                  stopped;
   } band_info_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_DIV,
      BE_SETUP,
      BE_PROD,
      BE_STEP,
      BE_FINISH
   } be_state_type;

   typedef enum logic [2:0] {
      BC_IDLE,
      BC_H3,
      BC_K,
      BC_K2,
      BC_SQ,
      BC_ROOT,
      BC_FIX,
      BC_OUT
   } bc_state_type;

endpackage

>>> sv/lbsb_band_end.sv
// Band boundary unit: end entry = max(min(floor(2^(1+10x/q)), cap), prev+1).
// Serial divider, then shift-and-add evaluation of 2^t; uses lbsb_pkg.
module lbsb_band_end import lbsb_pkg::*; #(
   parameter int FRAME_ENTRIES = 2048
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [BAND_W-1:0]                      band_index,
   input  logic [BAND_W-1:0]                      band_count,
   input  logic [$clog2(FRAME_ENTRIES)-1:0]       prev_pos,
   output logic                                   busy,
   output logic                                   done,
   output logic [$clog2(FRAME_ENTRIES+1)-1:0]     end_pos
);

   localparam int POS_W = $clog2(FRAME_ENTRIES);
   localparam int END_W = $clog2(FRAME_ENTRIES + 1);
   localparam int CMP_W = FLOOR_W + END_W;
   localparam int RES_W = EXP_FRAC + BAND_W;
   localparam int CAP   = FRAME_ENTRIES - 1;

   be_state_type         state_ff, state_in;
   logic [BAND_W-1:0]    q_ff, q_in;
   logic                 small_ff, small_in;
   logic                 big_ff, big_in;
   logic [POS_W-1:0]     prev_ff, prev_in;
   logic [DIV_W-1:0]     p_ff, p_in;
   logic [BAND_W:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic [RES_W-1:0]     res_ff, res_in;
   logic [RES_W:0]       prod_ff, prod_in;
   logic [EXP_FRAC:0]    y_ff, y_in;

   logic [BAND_W:0]      rem_sh;
   logic                 qbit;
   logic [STEP_W-1:0]    sh;
   logic [CMP_W-1:0]     cand;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      q_ff     <= q_in;
      small_ff <= small_in;
      big_ff   <= big_in;
      prev_ff  <= prev_in;
      p_ff     <= p_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      cnt_ff   <= cnt_in;
      res_ff   <= res_in;
      prod_ff  <= prod_in;
      y_ff     <= y_in;
   end

   always_comb begin
      state_in = state_ff;
      q_in     = q_ff;
      small_in = small_ff;
      big_in   = big_ff;
      prev_in  = prev_ff;
      p_in     = p_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      prod_in  = prod_ff;
      y_in     = y_ff;
      done     = 1'b0;
      rem_sh   = {rem_ff[BAND_W-1:0], p_ff[DIV_W-1]};
      qbit     = 1'b0;
      unique case (state_ff)
         BE_IDLE: begin
            if (start) begin
               q_in     = band_count - BAND_W'(1);
               small_in = (band_count <= BAND_W'(1));
               big_in   = 1'b0;
               prev_in  = prev_pos;
               p_in     = DIV_W'({band_index, 3'b000}) + DIV_W'({band_index, 1'b0});
               rem_in   = '0;
               quot_in  = '0;
               cnt_in   = '0;
               state_in = small_in ? BE_FINISH : BE_DIV;
            end
         end
         BE_DIV: begin
            if (rem_sh >= {1'b0, q_ff}) begin
               rem_in = rem_sh - {1'b0, q_ff};
               qbit   = 1'b1;
            end else begin
               rem_in = rem_sh;
            end
            quot_in = {quot_ff[DIV_W-2:0], qbit};
            p_in    = {p_ff[DIV_W-2:0], 1'b0};
            if (cnt_ff == STEP_W'(DIV_W - 1)) begin
               cnt_in   = '0;
               state_in = BE_SETUP;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         BE_SETUP: begin
            big_in   = (quot_ff >= DIV_W'(BIG_QUOT));
            res_in   = {rem_ff[BAND_W-1:0], {EXP_FRAC{1'b0}}};
            y_in     = {1'b1, {EXP_FRAC{1'b0}}};
            state_in = big_in ? BE_FINISH : BE_PROD;
         end
         BE_PROD: begin
            prod_in  = (RES_W + 1)'(q_ff) * (RES_W + 1)'(EXP_TAB[cnt_ff]);
            state_in = BE_STEP;
         end
         BE_STEP: begin
            // Take the step when the remaining exponent still covers log2(1+2^-k).
            if ({1'b0, res_ff} >= prod_ff) begin
               res_in = RES_W'({1'b0, res_ff} - prod_ff);
               y_in   = y_ff + (y_ff >> (cnt_ff + STEP_W'(1)));
            end
            if (cnt_ff == STEP_W'(EXP_FRAC - 1)) begin
               state_in = BE_FINISH;
            end else begin
               cnt_in   = cnt_ff + STEP_W'(1);
               state_in = BE_PROD;
            end
         end
         BE_FINISH: begin
            done     = 1'b1;
            state_in = BE_IDLE;
         end
         default: begin
            state_in = BE_IDLE;
         end
      endcase
   end

   always_comb begin
      sh = STEP_W'(EXP_FRAC - 1) - STEP_W'(quot_ff[3:0]);
      priority if (small_ff) begin
         cand = CMP_W'(FIRST_BAND_END);
      end else if (big_ff) begin
         cand = CMP_W'(CAP);
      end else begin
         cand = CMP_W'(FLOOR_W'(y_ff >> sh));
      end
      if (cand > CMP_W'(CAP)) begin
         cand = CMP_W'(CAP);
      end
      if (cand <= CMP_W'(prev_ff)) begin
         cand = CMP_W'(prev_ff) + CMP_W'(1);
      end
      end_pos = END_W'(cand);
   end

   assign busy = (state_ff != BE_IDLE);

endmodule

>>> sv/lbsb_front.sv
// Entry tracker: positions, band peaks and band ends; queues finished bands.
// Uses lbsb_pkg and lbsb_band_end.
module lbsb_front import lbsb_pkg::*; #(
   parameter int FRAME_ENTRIES = 2048,
   parameter int MAG_BITS      = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [MAG_BITS-1:0]  req_magnitude,
   input  logic                 req_frame_start,
   input  logic [BAND_W-1:0]    cfg_band_count,
   input  logic [HEIGHT_W-1:0]  cfg_bar_height,
   input  logic                 cfg_stopped,
   input  logic                 queue_full,
   output logic                 push,
   output logic [MAG_BITS-1:0]  push_left,
   output logic [MAG_BITS-1:0]  push_right,
   output band_info_type        push_info
);

   localparam int POS_W = $clog2(FRAME_ENTRIES);
   localparam int END_W = $clog2(FRAME_ENTRIES + 1);
   localparam int CAP   = FRAME_ENTRIES - 1;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [BAND_W-1:0]   band_ff, band_in;
   logic [END_W-1:0]    end_ff, end_in;
   logic [MAG_BITS-1:0] lpk_ff, lpk_in;
   logic [MAG_BITS-1:0] rpk_ff, rpk_in;

   logic                accept;
   logic [POS_W-1:0]    pos_next;
   logic [BAND_W-1:0]   band_next;
   logic [MAG_BITS-1:0] lpk_new, rpk_new;
   logic                calc_start, calc_busy, calc_done;
   logic [END_W-1:0]    calc_end;

   lbsb_band_end #(.FRAME_ENTRIES(FRAME_ENTRIES)) u_band_end (
      .clock      (clock),
      .reset      (reset),
      .start      (calc_start),
      .band_index (band_next),
      .band_count (cfg_band_count),
      .prev_pos   (pos_next),
      .busy       (calc_busy),
      .done       (calc_done),
      .end_pos    (calc_end)
   );

   assign req_ready = !calc_busy && !queue_full;
   assign accept    = req_valid && req_ready;
   assign pos_next  = pos_ff + POS_W'(1);
   assign band_next = band_ff + BAND_W'(1);
   // Odd positions belong to the right channel.
   assign lpk_new = (!pos_next[0] && (req_magnitude > lpk_ff)) ? req_magnitude : lpk_ff;
   assign rpk_new = (pos_next[0] && (req_magnitude > rpk_ff)) ? req_magnitude : rpk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         band_ff <= '0;
         end_ff  <= END_W'(FIRST_BAND_END);
         lpk_ff  <= '0;
         rpk_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         band_ff <= band_in;
         end_ff  <= end_in;
         lpk_ff  <= lpk_in;
         rpk_ff  <= rpk_in;
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      band_in    = band_ff;
      end_in     = calc_done ? calc_end : end_ff;
      lpk_in     = lpk_ff;
      rpk_in     = rpk_ff;
      push       = 1'b0;
      calc_start = 1'b0;
      push_left  = lpk_new;
      push_right = rpk_new;
      push_info.band    = band_ff[BAND_NUM_W-1:0];
      push_info.last    = (band_next == cfg_band_count);
      push_info.stopped = cfg_stopped;
      if (accept) begin
         priority if (req_frame_start) begin
            pos_in  = '0;
            band_in = '0;
            end_in  = END_W'(FIRST_BAND_END);
            lpk_in  = '0;
            rpk_in  = '0;
         end else if (pos_ff != POS_W'(CAP)) begin
            pos_in = pos_next;
            if (band_ff < cfg_band_count) begin
               lpk_in = lpk_new;
               rpk_in = rpk_new;
               if (END_W'(pos_next) >= end_ff) begin
                  push       = (cfg_bar_height != '0);
                  band_in    = band_next;
                  lpk_in     = '0;
                  rpk_in     = '0;
                  calc_start = (band_next < cfg_band_count);
               end
            end
         end
      end
   end

`ifndef SYNTHESIS
   a_end_ahead: assert property (@(posedge clock) disable iff (reset)
      calc_done |=> (END_W'(pos_ff) < end_ff))
      else $error("band end not beyond current position");
`endif

endmodule

>>> sv/lbsb_queue.sv
// Short queue of finished bands between the entry tracker and the bar unit.
// Uses lbsb_pkg for its depth.
module lbsb_queue import lbsb_pkg::*; #(
   parameter int DATA_W = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty,
   output logic              full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("queue count did not advance");
`endif

endmodule

>>> sv/lbsb_bar_calc.sv
// Bar unit: bar = trunc(sqrt(peak) * K / 256 - 4) per channel, or floor(height/3) if
// above height; a shared serial square root and a result register. Uses lbsb_pkg.
module lbsb_bar_calc import lbsb_pkg::*; #(
   parameter int MAG_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [MULT_W-1:0]      cfg_multiplier,
   input  logic [HEIGHT_W-1:0]    cfg_bar_height,
   input  logic                   q_empty,
   output logic                   q_pop,
   input  logic [MAG_BITS-1:0]    q_left,
   input  logic [MAG_BITS-1:0]    q_right,
   input  band_info_type          q_info,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [BAR_W-1:0] rsp_left_bar,
   output logic signed [BAR_W-1:0] rsp_right_bar,
   output logic [BAND_NUM_W-1:0]  rsp_band_number,
   output logic                   rsp_last_band
);

   localparam int SQ_W  = MAG_BITS + K2_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int CNT_W = $clog2(ROOT_W);

   bc_state_type         state_ff, state_in;
   logic [MAG_BITS-1:0]  lpk_ff, lpk_in;
   logic [MAG_BITS-1:0]  rpk_ff, rpk_in;
   band_info_type        info_ff, info_in;
   logic                 ch_ff, ch_in;
   logic [8:0]           h3_ff, h3_in;
   logic [K_W-1:0]       k_ff, k_in;
   logic [K2_W-1:0]      k2_ff, k2_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic [ROOT_IN_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [BAR_W-1:0]     lbar_ff, lbar_in;
   logic [BAR_W-1:0]     rbar_ff, rbar_in;
   logic                 out_valid_ff, out_valid_in;
   logic [BAR_W-1:0]     out_left_ff, out_left_in;
   logic [BAR_W-1:0]     out_right_ff, out_right_in;
   band_info_type        out_info_ff, out_info_in;

   logic [REM_W-1:0]       rem_sh, trial;
   logic signed [Y_W-1:0]  y;
   logic [3:0]             f_sq;
   logic                   exact;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BC_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      lpk_ff       <= lpk_in;
      rpk_ff       <= rpk_in;
      info_ff      <= info_in;
      ch_ff        <= ch_in;
      h3_ff        <= h3_in;
      k_ff         <= k_in;
      k2_ff        <= k2_in;
      sq_ff        <= sq_in;
      rad_ff       <= rad_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      cnt_ff       <= cnt_in;
      lbar_ff      <= lbar_in;
      rbar_ff      <= rbar_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      out_info_ff  <= out_info_in;
   end

   always_comb begin
      state_in     = state_ff;
      lpk_in       = lpk_ff;
      rpk_in       = rpk_ff;
      info_in      = info_ff;
      ch_in        = ch_ff;
      h3_in        = h3_ff;
      k_in         = k_ff;
      k2_in        = k2_ff;
      sq_in        = sq_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      lbar_in      = lbar_ff;
      rbar_in      = rbar_ff;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      out_info_in  = out_info_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      rem_sh       = {rem_ff[ROOT_W-1:0], rad_ff[ROOT_IN_W-1 -: 2]};
      trial        = {root_ff, 2'b01};
      f_sq         = 4'(root_ff[1:0] * root_ff[1:0]);
      exact        = (sq_ff == {SQ_W'(f_sq), {MAG_BITS{1'b0}}} >> MAG_BITS << MAG_BITS)
                     && (sq_ff == (SQ_W'(f_sq) << MAG_BITS));
      y            = '0;
      unique case (state_ff)
         BC_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               lpk_in  = q_left;
               rpk_in  = q_right;
               info_in = q_info;
               ch_in   = 1'b0;
               if (q_info.stopped) begin
                  lbar_in  = BAR_W'(BAR_STOPPED);
                  rbar_in  = BAR_W'(BAR_STOPPED);
                  state_in = BC_OUT;
               end else begin
                  state_in = BC_H3;
               end
            end
         end
         BC_H3: begin
            h3_in = 9'((20'(cfg_bar_height) * 20'(DIV3_RECIP)) >> DIV3_SHIFT);
            state_in = BC_K;
         end
         BC_K: begin
            k_in     = K_W'(K_W'(cfg_multiplier) * K_W'(h3_ff));
            state_in = BC_K2;
         end
         BC_K2: begin
            k2_in    = K2_W'(K2_W'(k_ff) * K2_W'(k_ff));
            state_in = BC_SQ;
         end
         BC_SQ: begin
            sq_in    = SQ_W'(ch_ff ? rpk_ff : lpk_ff) * SQ_W'(k2_ff);
            state_in = BC_ROOT;
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            rad_in   = sq_in[MAG_BITS +: ROOT_IN_W];
         end
         BC_ROOT: begin
            // One result bit per cycle, two radicand bits brought down each time.
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            rad_in = {rad_ff[ROOT_IN_W-3:0], 2'b00};
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               state_in = BC_FIX;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         BC_FIX: begin
            // Below four the exact product may fall short of the next integer.
            if (root_ff >= ROOT_W'(BAR_OFFSET)) begin
               y = Y_W'(root_ff) - Y_W'(BAR_OFFSET);
            end else if (exact) begin
               y = Y_W'(root_ff) - Y_W'(BAR_OFFSET);
            end else begin
               y = Y_W'(root_ff) + Y_W'(1) - Y_W'(BAR_OFFSET);
            end
            if (y > $signed(Y_W'(cfg_bar_height))) begin
               y = $signed(Y_W'(h3_ff));
            end
            if (ch_ff) begin
               rbar_in  = y[BAR_W-1:0];
               state_in = BC_OUT;
            end else begin
               lbar_in  = y[BAR_W-1:0];
               ch_in    = 1'b1;
               state_in = BC_SQ;
            end
         end
         BC_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_left_in  = lbar_ff;
               out_right_in = rbar_ff;
               out_info_in  = info_ff;
               state_in     = BC_IDLE;
            end
         end
         default: begin
            state_in = BC_IDLE;
         end
      endcase
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_left_bar    = $signed(out_left_ff);
   assign rsp_right_bar   = $signed(out_right_ff);
   assign rsp_band_number = out_info_ff.band;
   assign rsp_last_band   = out_info_ff.last;

endmodule

>>> sv/log_band_spectrum_bars_core.sv
// Logarithmic band bar generator for an interleaved stereo spectrum. Entries are
// taken one per cycle unless the queue is full; after each band end but the last,
// the input stalls while the next band boundary is computed (an 11-step divider,
// then 40 shift-and-add steps for the power of two). The bar unit shares one
// serial square root between both channels; a four-deep queue lets the two parts
// run apart.
module log_band_spectrum_bars_core import lbsb_pkg::*; #(
   parameter int FRAME_ENTRIES = 2048,
   parameter int MAG_BITS      = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [MAG_BITS-1:0]     req_magnitude,
   input  logic                    req_frame_start,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [BAR_W-1:0] rsp_left_bar,
   output logic signed [BAR_W-1:0] rsp_right_bar,
   output logic [BAND_NUM_W-1:0]   rsp_band_number,
   output logic                    rsp_last_band,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_data
);

   localparam int INFO_W = $bits(band_info_type);
   localparam int DATA_W = 2 * MAG_BITS + INFO_W;

   logic [BAND_W-1:0]   band_count_ff, band_count_in;
   logic [MULT_W-1:0]   multiplier_ff, multiplier_in;
   logic [HEIGHT_W-1:0] bar_height_ff, bar_height_in;
   logic                stopped_ff, stopped_in;

   logic                push, pop, q_empty, q_full;
   logic [MAG_BITS-1:0] push_left, push_right;
   band_info_type       push_info, pop_info;
   logic [DATA_W-1:0]   push_data, pop_data;

   always_comb begin
      band_count_in = band_count_ff;
      multiplier_in = multiplier_ff;
      bar_height_in = bar_height_ff;
      stopped_in    = stopped_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BAND_COUNT:   band_count_in = csr_data[BAND_W-1:0];
            CSR_MULTIPLIER:   multiplier_in = csr_data[MULT_W-1:0];
            CSR_BAR_HEIGHT:   bar_height_in = csr_data[HEIGHT_W-1:0];
            CSR_STOPPED_MODE: stopped_in    = csr_data[0];
            default:          stopped_in    = stopped_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_count_ff <= BAND_COUNT_RST;
         multiplier_ff <= MULTIPLIER_RST;
         bar_height_ff <= BAR_HEIGHT_RST;
         stopped_ff    <= STOPPED_RST;
      end else begin
         band_count_ff <= band_count_in;
         multiplier_ff <= multiplier_in;
         bar_height_ff <= bar_height_in;
         stopped_ff    <= stopped_in;
      end
   end

   lbsb_front #(.FRAME_ENTRIES(FRAME_ENTRIES), .MAG_BITS(MAG_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_magnitude   (req_magnitude),
      .req_frame_start (req_frame_start),
      .cfg_band_count  (band_count_ff),
      .cfg_bar_height  (bar_height_ff),
      .cfg_stopped     (stopped_ff),
      .queue_full      (q_full),
      .push            (push),
      .push_left       (push_left),
      .push_right      (push_right),
      .push_info       (push_info)
   );

   assign push_data = {push_left, push_right, push_info};

   lbsb_queue #(.DATA_W(DATA_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   assign pop_info = pop_data[INFO_W-1:0];

   lbsb_bar_calc #(.MAG_BITS(MAG_BITS)) u_bar_calc (
      .clock           (clock),
      .reset           (reset),
      .cfg_multiplier  (multiplier_ff),
      .cfg_bar_height  (bar_height_ff),
      .q_empty         (q_empty),
      .q_pop           (pop),
      .q_left          (pop_data[DATA_W-1 -: MAG_BITS]),
      .q_right         (pop_data[INFO_W +: MAG_BITS]),
      .q_info          (pop_info),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_bar    (rsp_left_bar),
      .rsp_right_bar   (rsp_right_bar),
      .rsp_band_number (rsp_band_number),
      .rsp_last_band   (rsp_last_band)
   );

endmodule

>>> tb/sv/lbsb_checker.sv
// Checker for the logarithmic band spectrum bar generator: it watches the channels and the
// register port, predicts the band results and compares them. Depends on lbsb_pkg.
module lbsb_checker import lbsb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [15:0]             req_magnitude,
   input  logic                    req_frame_start,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [BAR_W-1:0] rsp_left_bar,
   input  logic signed [BAR_W-1:0] rsp_right_bar,
   input  logic [BAND_NUM_W-1:0]   rsp_band_number,
   input  logic                    rsp_last_band,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_data,
   output int                      fail_count,
   output int                      pending,
   output int                      result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LAST_ENTRY = 2047;

   typedef struct {
      logic signed [BAR_W-1:0] left_bar;
      logic signed [BAR_W-1:0] right_bar;
      logic [BAND_NUM_W-1:0]   band_number;
      logic                    last_band;
   } bar_result_type;

   bar_result_type expected_bars[$];

   logic [BAND_W-1:0]   cfg_bands;
   logic [MULT_W-1:0]   cfg_gain;
   logic [HEIGHT_W-1:0] cfg_height;
   logic                cfg_stopped;

   int unsigned position, band_idx, band_stop;
   int unsigned left_peak, right_peak;

   // True when base^count <= 2^exponent, with exact wide arithmetic.
   function automatic bit power_fits(int unsigned base, int unsigned count,
                                     int unsigned exponent);
      bit [2047:0] acc;
      bit [2047:0] bound;
      acc = 1;
      bound = 0;
      bound[exponent] = 1'b1;
      for (int i = 0; i < count; i++) begin
         acc = acc * base;
         if (acc > bound) return 0;
      end
      return 1;
   endfunction

   function automatic int unsigned boundary(int unsigned x, int unsigned prev);
      int unsigned q, p, ip, r, lo, hi, mid, f;
      if (cfg_bands <= 1) begin
         f = 2;
      end else begin
         q = cfg_bands - 1;
         p = 10 * x;
         ip = 1 + p / q;
         r = p % q;
         if (ip >= 14) begin
            f = LAST_ENTRY;
         end else begin
            lo = 1 << ip;
            hi = (1 << (ip + 1)) - 1;
            while (lo < hi) begin
               mid = (lo + hi + 1) / 2;
               if (power_fits(mid, q, ip * q + r)) lo = mid;
               else hi = mid - 1;
            end
            f = lo;
         end
      end
      if (f > LAST_ENTRY) f = LAST_ENTRY;
      if (f <= prev) f = prev + 1;
      return f;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [BAR_W-1:0] bar_of(int unsigned peak);
      longint unsigned h3, k, sq, f, c;
      int y;
      h3 = cfg_height / 3;
      k = cfg_gain * h3;
      sq = peak * k * k;
      f = int_sqrt(sq >> 16);
      if (f >= 4) begin
         y = int'(f) - 4;
      end else begin
         // Below four the rounding toward zero needs to know whether the root is exact.
         c = ((f * f) << 16) == sq ? f : f + 1;
         y = int'(c) - 4;
      end
      if (y > int'(cfg_height)) y = int'(h3);
      return BAR_W'(y);
   endfunction

   task automatic take_entry(logic [15:0] mag, logic fs);
      bar_result_type res;
      if (fs) begin
         position = 0;
         band_idx = 0;
         left_peak = 0;
         right_peak = 0;
         band_stop = boundary(0, 0);
         return;
      end
      if (position >= LAST_ENTRY) return;
      position++;
      if (band_idx >= cfg_bands) return;
      if (position[0]) begin
         if (mag > right_peak) right_peak = mag;
      end else begin
         if (mag > left_peak) left_peak = mag;
      end
      if (position < band_stop) return;
      if (cfg_stopped) begin
         res.left_bar = BAR_STOPPED;
         res.right_bar = BAR_STOPPED;
      end else begin
         res.left_bar = bar_of(left_peak);
         res.right_bar = bar_of(right_peak);
      end
      res.band_number = BAND_NUM_W'(band_idx);
      res.last_band = (band_idx + 1 == cfg_bands);
      band_idx++;
      left_peak = 0;
      right_peak = 0;
      if (band_idx < cfg_bands) band_stop = boundary(band_idx, position);
      if (cfg_height != 0) expected_bars.push_back(res);
   endtask

   always @(posedge clock) begin
      bar_result_type e;
      if (reset) begin
         cfg_bands = BAND_COUNT_RST;
         cfg_gain = MULTIPLIER_RST;
         cfg_height = BAR_HEIGHT_RST;
         cfg_stopped = STOPPED_RST;
         position = 0;
         band_idx = 0;
         band_stop = FIRST_BAND_END;
         left_peak = 0;
         right_peak = 0;
         fail_count = 0;
         result_count = 0;
         expected_bars.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_bars.size() == 0) begin
               $display("%0t: result with nothing expected: band %0d left %0d right %0d",
                        $time, rsp_band_number, rsp_left_bar, rsp_right_bar);
               fail_count++;
            end else begin
               e = expected_bars.pop_front();
               if (e.left_bar !== rsp_left_bar || e.right_bar !== rsp_right_bar ||
                   e.band_number !== rsp_band_number || e.last_band !== rsp_last_band) begin
                  $display("%0t: mismatch expected left %0d right %0d band %0d last %0b",
                           $time, e.left_bar, e.right_bar, e.band_number, e.last_band);
                  $display("%0t:          actual   left %0d right %0d band %0d last %0b",
                           $time, rsp_left_bar, rsp_right_bar, rsp_band_number,
                           rsp_last_band);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) take_entry(req_magnitude, req_frame_start);
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BAND_COUNT:   cfg_bands = csr_data[BAND_W-1:0];
               CSR_MULTIPLIER:   cfg_gain = csr_data[MULT_W-1:0];
               CSR_BAR_HEIGHT:   cfg_height = csr_data[HEIGHT_W-1:0];
               CSR_STOPPED_MODE: cfg_stopped = csr_data[0];
               default: ;
            endcase
         end
      end
      pending = expected_bars.size();
   end
endmodule

>>> tb/sv/tb.sv
// Top of the testbench: clock, reset, register settings and spectrum frames for the block,
// with the checker beside it. Depends on lbsb_pkg, lbsb_checker and the core.
module tb;
   import lbsb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid, req_ready, req_frame_start;
   logic [15:0]             req_magnitude;
   logic                    rsp_valid, rsp_ready, rsp_last_band;
   logic signed [BAR_W-1:0] rsp_left_bar, rsp_right_bar;
   logic [BAND_NUM_W-1:0]   rsp_band_number;
   logic                    csr_write_enable;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_W-1:0]        csr_data;
   int                      fail_count, pending, result_count;
   int                      item_count = 0;
   int                      phase_count = 0;
   bit                      quiet = 0;
   bit                      hold_off = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   log_band_spectrum_bars_core i_dut (.*);

   lbsb_checker i_checker (.*);

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic send_entry(logic [15:0] mag, logic fs);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_magnitude <= mag;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
      item_count++;
   endtask

   function automatic logic [15:0] random_mag();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_frame(int len);
      send_entry(random_mag(), 1'b1);
      for (int i = 0; i < len; i++) begin
         // A stray frame start now and then breaks the frame early.
         if ($urandom_range(0, 99) == 0) send_entry(random_mag(), 1'b1);
         else send_entry(random_mag(), 1'b0);
      end
   endtask

   // Waits for every expected band, then lets the band end unit finish its work.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic configure(int bands, int gain, int height, int stopped);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_BAND_COUNT;
      csr_data <= CSR_W'(bands);
      @(posedge clock);
      csr_index <= CSR_MULTIPLIER;
      csr_data <= CSR_W'(gain);
      @(posedge clock);
      csr_index <= CSR_BAR_HEIGHT;
      csr_data <= CSR_W'(height);
      @(posedge clock);
      csr_index <= CSR_STOPPED_MODE;
      csr_data <= CSR_W'(stopped);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      phase_count++;
   endtask

   task automatic random_phase(int bands, int gain, int height, int stopped, int entries);
      int sent;
      configure(bands, gain, height, stopped);
      sent = 0;
      while (sent < entries) begin
         int len;
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(150, 400)
                                            : $urandom_range(1, 120);
         if (len > entries - sent - 1) len = entries - sent - 1;
         send_frame(len);
         sent += len + 1;
      end
      drain();
   endtask

   always begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (800) @(posedge clock);
            hold_off = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_magnitude <= '0;
      req_frame_start <= 1'b0;
      rsp_ready <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_BAND_COUNT;
      csr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings give no output; then extremes of magnitude and gain.
      send_entry(16'hFFFF, 1'b0);
      send_entry(16'hFFFF, 1'b0);
      drain();
      configure(2, 15, 1023, 0);
      send_entry(16'h1234, 1'b1);
      send_entry(16'hFFFF, 1'b0);
      send_entry(16'd0, 1'b0);
      send_entry(16'd1, 1'b1);
      send_entry(16'd1, 1'b0);
      send_entry(16'd1, 1'b0);
      drain();
      configure(3, 1, 1023, 0);
      send_entry(16'd0, 1'b1);
      for (int i = 0; i < 6; i++) send_entry(i[0] ? 16'h8000 : 16'h0010, 1'b0);
      drain();
      configure(4, 15, 1, 1);
      send_entry(16'd0, 1'b1);
      for (int i = 0; i < 6; i++) send_entry(16'hFFFF, 1'b0);
      drain();

      random_phase(28, 3, 300, 0, 110);
      hold_off = 1;
      random_phase(64, 15, 1023, 0, 110);
      random_phase(2, 0, 1023, 0, 100);
      random_phase(0, 7, 500, 0, 80);
      random_phase(1, 9, 3, 0, 80);
      random_phase(127, 5, 700, 0, 110);
      random_phase(20, 15, 2, 0, 100);
      random_phase(16, 4, 1023, 1, 100);
      random_phase(40, 8, 0, 0, 100);
      random_phase(33, 11, 999, 0, 100);
      quiet = 1;
      random_phase(10, 15, 1023, 0, 138);

      $display("Sent %0d entries under %0d register settings; %0d band results compared.",
               item_count, phase_count, result_count);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
